FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock, disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion on the usual i_clk / i_rst_n pair of a module.
`define ASSERT_STD(label, prop, msg) \
    `ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

FILE: src/i2cme_pkg.sv
package i2cme_pkg;

    // Raw opcode values on the request channel.
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_WAIT  = 3'd5;

    // Command in progress; also the state of the bus sequencer.
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_WAIT  = 3'd5
    } t_cmd;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 1'b1;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers.
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd50;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd100;

    // Default depth of the request and result queues.
    localparam int QUEUE_DEPTH = 2;

    // One classified tick request.
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data_byte;
        logic       send_nack;
        logic       sda_in;
    } t_tick;

    // One result of a tick.
    typedef struct packed {
        logic       scl_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       no_ack;
    } t_result;

    // Configuration as seen by the engine.
    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [7:0]  ack_timeout;
    } t_cfg;

endpackage

FILE: src/i2c_master_byte_engine_core.sv
// Channel   | Direction | Handshake                      | Payload
// ----------+-----------+--------------------------------+----------------------------------
// request   | in        | push / full                    | opcode, data_byte, send_nack, sda_in
// result    | out       | empty / pop                    | scl_out, sda_drive, busy_res,
//           |           |                                | done_res, read_data, no_ack
// config    | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// One request is one bus tick; the sequencer retires one tick per clock while the result
// queue has room, so the block sustains one request per cycle unless the result side stalls.
// A request is registered in the tick queue and its result in the result queue before it can be popped.
// Reset is synchronous; the block takes requests from the first cycle after it.
// full rises only while the result side is stalled long enough to fill both queues.
module i2c_master_byte_engine_core #(
    parameter int P_QUEUE_DEPTH = i2cme_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [2:0]                       i_opcode,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_send_nack,
    input  logic                             i_sda_in,
    output logic                             empty,
    input  logic                             pop,
    output logic                             o_scl_out,
    output logic                             o_sda_drive,
    output logic                             o_busy_res,
    output logic                             o_done_res,
    output logic [7:0]                       o_read_data,
    output logic                             o_no_ack,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [i2cme_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [i2cme_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import i2cme_pkg::*;

    t_cfg    r_cfg;
    t_tick   tick;
    logic    tick_empty;
    logic    tick_pop;
    t_result result;

    // Configuration registers, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= HALF_PERIOD_RESET;
            r_cfg.ack_timeout       <= ACK_TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_HALF_PERIOD: r_cfg.half_period_ticks <= i_cfg_data;
                REG_ACK_TIMEOUT: r_cfg.ack_timeout       <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Request intake and classification.
    i2cme_front #(
        .P_QUEUE_DEPTH (P_QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .i_send_nack (i_send_nack),
        .i_sda_in    (i_sda_in),
        .o_tick      (tick),
        .o_empty     (tick_empty),
        .i_pop       (tick_pop)
    );

    // Bus sequencer and result queue.
    i2cme_engine #(
        .P_QUEUE_DEPTH (P_QUEUE_DEPTH)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_tick       (tick),
        .i_tick_empty (tick_empty),
        .o_tick_pop   (tick_pop),
        .o_result     (result),
        .o_empty      (empty),
        .i_pop        (pop)
    );

    // Result fields to ports.
    assign o_scl_out   = result.scl_out;
    assign o_sda_drive = result.sda_drive;
    assign o_busy_res  = result.busy_res;
    assign o_done_res  = result.done_res;
    assign o_read_data = result.read_data;
    assign o_no_ack    = result.no_ack;

endmodule

FILE: src/i2cme_fifo.sv
`include "assert_macros.svh"

module i2cme_fifo #(
    parameter int P_DEPTH = 2,
    parameter int P_WIDTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [P_WIDTH-1:0] i_wdata,
    output logic               o_full,
    input  logic               i_pop,
    output logic [P_WIDTH-1:0] o_rdata,
    output logic               o_empty
);
    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               wr_en, rd_en;

    // Handshake qualification.
    assign o_full  = (r_count == CNT_W'(P_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    // Pointer wrap and fill count.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({wr_en, rd_en})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            2'b11:   n_count = r_count;
            default: n_count = r_count;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    `ASSERT_STD(a_count_bound, r_count <= CNT_W'(P_DEPTH), "fifo count beyond depth")
    `ASSERT_STD(a_count_up, wr_en && !rd_en |=> r_count == $past(r_count) + 1'b1, "fifo count missed a push")
    `ASSERT_STD(a_count_down, rd_en && !wr_en |=> r_count == $past(r_count) - 1'b1, "fifo count missed a pop")

endmodule

FILE: src/i2cme_front.sv
module i2cme_front #(
    parameter int P_QUEUE_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [2:0]        i_opcode,
    input  logic [7:0]        i_data_byte,
    input  logic              i_send_nack,
    input  logic              i_sda_in,
    output i2cme_pkg::t_tick  o_tick,
    output logic              o_empty,
    input  logic              i_pop
);
    import i2cme_pkg::*;

    t_tick tick_in;

    // Map the raw opcode to a command; unknown codes mean no command.
    function automatic t_cmd decode_op(logic [2:0] op);
        t_cmd cmd;
        unique case (op)
            OP_START: cmd = CMD_START;
            OP_STOP:  cmd = CMD_STOP;
            OP_WRITE: cmd = CMD_WRITE;
            OP_READ:  cmd = CMD_READ;
            OP_WAIT:  cmd = CMD_WAIT;
            default:  cmd = CMD_NONE;
        endcase
        return cmd;
    endfunction

    // Classify the request before it enters the queue.
    always_comb begin
        tick_in.cmd       = decode_op(i_opcode);
        tick_in.data_byte = i_data_byte;
        tick_in.send_nack = i_send_nack;
        tick_in.sda_in    = i_sda_in;
    end

    // Queue between request side and the sequencer.
    i2cme_fifo #(
        .P_DEPTH (P_QUEUE_DEPTH),
        .P_WIDTH ($bits(t_tick))
    ) u_tick_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata (tick_in),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_rdata (o_tick),
        .o_empty (o_empty)
    );

endmodule

FILE: src/i2cme_engine.sv
`include "assert_macros.svh"

module i2cme_engine #(
    parameter int P_QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2cme_pkg::t_cfg     i_cfg,
    input  i2cme_pkg::t_tick    i_tick,
    input  logic                i_tick_empty,
    output logic                o_tick_pop,
    output i2cme_pkg::t_result  o_result,
    output logic                o_empty,
    input  logic                i_pop
);
    import i2cme_pkg::*;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_FIRST = 5'd0;
    localparam logic [STEP_W-1:0] STEP_POLL  = 5'd1;
    localparam logic [STEP_W-1:0] STEP_ACK   = 5'd16;

    t_cmd              r_cmd, n_cmd;
    logic [STEP_W-1:0] r_step, n_step;
    logic [15:0]       r_timer, n_timer;
    logic [7:0]        r_wait, n_wait;
    logic [7:0]        r_shift, n_shift;
    logic [7:0]        r_rx, n_rx;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic              r_ack_failed, n_ack_failed;
    logic              r_ack_choice, n_ack_choice;
    logic              n_done;
    logic [15:0]       period;
    logic [STEP_W-1:0] next_step;
    logic              out_full;
    t_result           result;

    // Number of bus phases in each command.
    function automatic logic [STEP_W-1:0] series_len(t_cmd cmd);
        logic [STEP_W-1:0] len;
        unique case (cmd)
            CMD_START: len = 5'd3;
            CMD_STOP:  len = 5'd3;
            CMD_WRITE: len = 5'd16;
            CMD_READ:  len = 5'd18;
            CMD_WAIT:  len = 5'd2;
            default:   len = 5'd0;
        endcase
        return len;
    endfunction

    // Bus levels on entry to a phase; returns {scl, sda}.
    function automatic logic [1:0] step_levels(t_cmd cmd, logic [STEP_W-1:0] step,
                                               logic data_msb, logic ack_choice,
                                               logic scl_now, logic sda_now);
        logic scl;
        logic sda;
        scl = scl_now;
        sda = sda_now;
        unique case (cmd)
            CMD_START: begin
                if (step == 5'd0) begin
                    sda = 1'b1;
                end else if (step == 5'd1) begin
                    scl = 1'b1;
                end else begin
                    sda = 1'b0;
                end
            end
            CMD_STOP: begin
                if (step == 5'd0) begin
                    scl = 1'b0;
                    sda = 1'b0;
                end else if (step == 5'd1) begin
                    scl = 1'b1;
                end else begin
                    sda = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (!step[0]) begin
                    scl = 1'b0;
                    sda = data_msb;
                end else begin
                    scl = 1'b1;
                end
            end
            CMD_READ: begin
                if (step < STEP_ACK) begin
                    if (!step[0]) begin
                        scl = 1'b0;
                        sda = 1'b1;
                    end else begin
                        scl = 1'b1;
                    end
                end else if (step == STEP_ACK) begin
                    scl = 1'b0;
                    sda = ack_choice;
                end else begin
                    scl = 1'b1;
                end
            end
            CMD_WAIT: begin
                scl = 1'b1;
                sda = 1'b1;
            end
            default: begin
                scl = scl_now;
                sda = sda_now;
            end
        endcase
        return {scl, sda};
    endfunction

    // One tick of the sequencer per request taken from the queue.
    always_comb begin
        n_cmd        = r_cmd;
        n_step       = r_step;
        n_timer      = r_timer;
        n_wait       = r_wait;
        n_shift      = r_shift;
        n_rx         = r_rx;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_ack_failed = r_ack_failed;
        n_ack_choice = r_ack_choice;
        n_done       = 1'b0;
        next_step    = r_step + 1'b1;
        period       = (i_cfg.half_period_ticks == '0) ? 16'd1 : i_cfg.half_period_ticks;
        o_tick_pop   = !i_tick_empty && !out_full;

        if (o_tick_pop) begin
            priority if (r_cmd == CMD_NONE) begin
                // Idle: a valid command starts its first phase.
                if (i_tick.cmd != CMD_NONE) begin
                    n_cmd        = i_tick.cmd;
                    n_wait       = '0;
                    n_shift      = (i_tick.cmd == CMD_WRITE) ? i_tick.data_byte : 8'd0;
                    n_ack_choice = i_tick.send_nack;
                    if (i_tick.cmd == CMD_WAIT) begin
                        n_ack_failed = 1'b0;
                    end
                    n_step  = STEP_FIRST;
                    n_timer = 16'd1;
                    {n_scl, n_sda} = step_levels(i_tick.cmd, STEP_FIRST, n_shift[7],
                                                 i_tick.send_nack, r_scl, r_sda);
                end
            end else if (r_cmd == CMD_WAIT && r_step == STEP_POLL) begin
                // Acknowledge polling with timeout into a stop sequence.
                if (!i_tick.sda_in) begin
                    n_scl   = 1'b0;
                    n_cmd   = CMD_NONE;
                    n_step  = '0;
                    n_timer = '0;
                    n_done  = 1'b1;
                end else if (r_wait >= i_cfg.ack_timeout) begin
                    n_ack_failed = 1'b1;
                    n_cmd        = CMD_STOP;
                    n_step       = STEP_FIRST;
                    n_timer      = 16'd1;
                    {n_scl, n_sda} = step_levels(CMD_STOP, STEP_FIRST, r_shift[7],
                                                 r_ack_choice, r_scl, r_sda);
                end else begin
                    n_wait = r_wait + 1'b1;
                end
            end else if (r_timer >= period) begin
                // Phase over: shift on the end of a data high phase, then advance.
                if (r_step[0] && r_step < STEP_ACK) begin
                    if (r_cmd == CMD_WRITE) begin
                        n_shift = {r_shift[6:0], 1'b0};
                    end else if (r_cmd == CMD_READ) begin
                        n_shift = {r_shift[6:0], i_tick.sda_in};
                    end
                end
                if (next_step >= series_len(r_cmd)) begin
                    if (r_cmd == CMD_READ) begin
                        n_rx = n_shift;
                    end
                    if (r_cmd != CMD_STOP) begin
                        n_scl = 1'b0;
                    end
                    n_cmd   = CMD_NONE;
                    n_step  = '0;
                    n_timer = '0;
                    n_done  = 1'b1;
                end else begin
                    n_step  = next_step;
                    n_timer = 16'd1;
                    {n_scl, n_sda} = step_levels(r_cmd, next_step, n_shift[7],
                                                 r_ack_choice, r_scl, r_sda);
                end
            end else begin
                n_timer = r_timer + 1'b1;
            end
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= CMD_NONE;
        end else begin
            r_cmd <= n_cmd;
        end
    end

    // Remaining sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= '0;
            r_timer      <= '0;
            r_wait       <= '0;
            r_shift      <= '0;
            r_rx         <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_ack_failed <= 1'b0;
            r_ack_choice <= 1'b0;
        end else begin
            r_step       <= n_step;
            r_timer      <= n_timer;
            r_wait       <= n_wait;
            r_shift      <= n_shift;
            r_rx         <= n_rx;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_ack_failed <= n_ack_failed;
            r_ack_choice <= n_ack_choice;
        end
    end

    // Result of this tick, after the update.
    always_comb begin
        result.scl_out   = n_scl;
        result.sda_drive = n_sda;
        result.busy_res  = (n_cmd != CMD_NONE);
        result.done_res  = n_done;
        result.read_data = n_rx;
        result.no_ack    = n_ack_failed;
    end

    // Result queue toward the consumer.
    i2cme_fifo #(
        .P_DEPTH (P_QUEUE_DEPTH),
        .P_WIDTH ($bits(t_result))
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (o_tick_pop),
        .i_wdata (result),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_rdata (o_result),
        .o_empty (o_empty)
    );

    `ASSERT_STD(a_step_in_series, r_cmd != CMD_NONE |-> r_step < series_len(r_cmd), "phase step beyond its series")
    `ASSERT_STD(a_timer_running, r_cmd != CMD_NONE |-> r_timer != 16'd0, "phase timer idle during a command")
    `ASSERT_STD(a_timeout_stops, $rose(r_ack_failed) |-> r_cmd == CMD_STOP, "timeout without stop sequence")
    `ASSERT_STD(a_ack_ends_wait, o_tick_pop && r_cmd == CMD_WAIT && r_step == STEP_POLL && !i_tick.sda_in |=> r_cmd == CMD_NONE, "acknowledge did not end the wait")

endmodule
